### design/hbct_pkg.sv
// shared types and constants of the hashed buffer cache tag manager
package hbct_pkg;

  localparam int unsigned BKT_W = 6;
  localparam logic [7:0] REFS_MAX = 8'hFF;

  typedef enum logic [1:0] {
    OP_READ    = 2'd0,
    OP_RELEASE = 2'd1,
    OP_PIN     = 2'd2,
    OP_UNPIN   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_e;

  typedef struct packed {
    opcode_e          op;
    logic [7:0]       dev;
    logic [31:0]      blk;
    logic [4:0]       idx;
    logic [BKT_W-1:0] bkt;
  } hbct_item_t;

endpackage

### design/hashed_buffer_cache_tags_top.sv
// read: quickest on a hit at the head of its list; the back may walk every list,
// one entry a cycle
// release, pin, unpin: no list walk; the front takes a new item only once it has pushed
// the last (a read's bucket by reciprocal multiplication), overlapping the back through a
// two-item queue; a held result in the output register stalls the back
// reset: asynchronous active low, restores all tags, counts and the initial bucket lists at once
module hashed_buffer_cache_tags_top import hbct_pkg::*; #(
  parameter int unsigned NUM_BUFFERS = 32,
  parameter int unsigned NUM_BUCKETS = 13
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  device_i,
  input  logic [31:0] block_number_i,
  input  logic [4:0]  buffer_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  entry_index_o,
  output logic        hit_o,
  output logic        needs_disk_read_o,
  output logic [1:0]  status_o
);

  logic       f_valid;
  logic       f_ready;
  hbct_item_t f_item;
  logic       b_valid;
  logic       b_ready;
  hbct_item_t b_item;

  hbct_front #(.NUM_BUCKETS(NUM_BUCKETS)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .opcode_i, .device_i,
    .block_number_i, .buffer_index_i,
    .push_valid_o(f_valid), .push_ready_i(f_ready), .push_item_o(f_item)
  );

  hbct_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_item_i(f_item),
    .rd_valid_o(b_valid), .rd_ready_i(b_ready), .rd_item_o(b_item)
  );

  hbct_back #(.NUM_BUFFERS(NUM_BUFFERS), .NUM_BUCKETS(NUM_BUCKETS)) u_back (
    .clk_i, .rst_ni,
    .pop_valid_i(b_valid), .pop_ready_o(b_ready), .pop_item_i(b_item),
    .out_valid_o, .out_ready_i, .entry_index_o, .hit_o, .needs_disk_read_o, .status_o
  );

  a_nofree_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_NO_FREE |-> entry_index_o == 5'd0 && !hit_o
      && !needs_disk_read_o)
    else $error("no free buffer result carries data");

  a_disk_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && needs_disk_read_o |-> status_o == ST_OK)
    else $error("disk read flagged on failed item");

  a_hit_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> status_o == ST_OK || status_o == ST_OVERFLOW)
    else $error("hit with bad status");

endmodule

### design/hbct_front.sv
// front end: takes items and works out the bucket of a read by reciprocal multiplication
module hbct_front import hbct_pkg::*; #(
  parameter int unsigned NUM_BUCKETS = 13
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  device_i,
  input  logic [31:0] block_number_i,
  input  logic [4:0]  buffer_index_i,
  output logic        push_valid_o,
  input  logic        push_ready_i,
  output hbct_item_t  push_item_o
);

  localparam int unsigned LG = $clog2(NUM_BUCKETS);
  localparam int unsigned SH = 32 + LG;
  localparam logic [63:0] RECIP =
    ((64'd1 << SH) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS);
  localparam logic [31:0] NK = 32'(NUM_BUCKETS);

  typedef enum logic [2:0] {F_IDLE, F_MLO, F_MHI, F_REM, F_PUSH} fstate_e;

  fstate_e     state_q;
  hbct_item_t  item_q;
  logic [64:0] prod_q;
  logic [47:0] mul_lo;
  logic [48:0] mul_hi;
  logic [31:0] quo;
  logic [31:0] rem;

  // quotient from the product with the rounded-up reciprocal, in two halves
  assign mul_lo = {16'd0, item_q.blk} * {32'd0, RECIP[15:0]};
  assign mul_hi = {17'd0, item_q.blk} * {32'd0, RECIP[32:16]};
  assign quo    = 32'(prod_q >> SH);
  assign rem    = item_q.blk - quo * NK;

  assign in_ready_o   = (state_q == F_IDLE);
  assign push_valid_o = (state_q == F_PUSH);
  assign push_item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      prod_q  <= '0;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (in_valid_i) begin
            item_q.op  <= opcode_e'(opcode_i);
            item_q.dev <= device_i;
            item_q.blk <= block_number_i;
            item_q.idx <= buffer_index_i;
            item_q.bkt <= '0;
            state_q    <= (opcode_e'(opcode_i) == OP_READ) ? F_MLO : F_PUSH;
          end
        end
        F_MLO: begin
          prod_q  <= {17'd0, mul_lo};
          state_q <= F_MHI;
        end
        F_MHI: begin
          prod_q  <= prod_q + {mul_hi, 16'd0};
          state_q <= F_REM;
        end
        F_REM: begin
          item_q.bkt <= rem[BKT_W-1:0];
          state_q    <= F_PUSH;
        end
        F_PUSH: begin
          if (push_ready_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

### design/hbct_queue.sv
// two-entry queue between front and back
module hbct_queue import hbct_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       wr_valid_i,
  output logic       wr_ready_o,
  input  hbct_item_t wr_item_i,
  output logic       rd_valid_o,
  input  logic       rd_ready_i,
  output hbct_item_t rd_item_o
);

  hbct_item_t slot_q [2];
  logic       wp_q;
  logic       rp_q;
  logic [1:0] cnt_q;
  logic       wr_en;
  logic       rd_en;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_item_o  = slot_q[rp_q];
  assign wr_en      = wr_valid_i && wr_ready_o;
  assign rd_en      = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_q[wp_q] <= wr_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (wr_en) begin
        wp_q <= ~wp_q;
      end
      if (rd_en) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

endmodule

### design/hbct_back.sv
// back end: tag store, bucket lists and the list-walking sequencer
module hbct_back import hbct_pkg::*; #(
  parameter int unsigned NUM_BUFFERS = 32,
  parameter int unsigned NUM_BUCKETS = 13
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       pop_valid_i,
  output logic       pop_ready_o,
  input  hbct_item_t pop_item_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [4:0] entry_index_o,
  output logic       hit_o,
  output logic       needs_disk_read_o,
  output logic [1:0] status_o
);

  localparam int unsigned BW  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int unsigned EW  = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam int unsigned LW  = $clog2(NUM_BUFFERS + 1);
  localparam int unsigned PER = NUM_BUFFERS / NUM_BUCKETS;
  localparam logic [LW-1:0] NIL = '1;
  localparam logic [BW-1:0] LAST_BKT = BW'(NUM_BUCKETS - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_HSCAN, S_FHEAD, S_FSCAN, S_UNLINK, S_PUSH, S_RETAG, S_OUT
  } bstate_e;

  function automatic int bstart(int b);
    return b * PER;
  endfunction

  function automatic int bend(int b);
    return (b == NUM_BUCKETS - 1) ? NUM_BUFFERS - 1 : b * PER + PER - 1;
  endfunction

  logic [7:0]    dev_q   [NUM_BUFFERS];
  logic [31:0]   blk_q   [NUM_BUFFERS];
  logic          val_q   [NUM_BUFFERS];
  logic [7:0]    refs_q  [NUM_BUFFERS];
  logic [LW-1:0] next_q  [NUM_BUFFERS];
  logic [LW-1:0] prev_q  [NUM_BUFFERS];
  logic [LW-1:0] first_q [NUM_BUCKETS];
  logic [LW-1:0] last_q  [NUM_BUCKETS];

  bstate_e    state_q;
  hbct_item_t item_q;
  logic [LW-1:0] cur_q;
  logic [BW-1:0] bk_q;
  logic [BW-1:0] tries_q;
  logic [LW-1:0] ent_q;
  logic       hit_q;
  logic       disk_q;
  status_e    st_q;
  logic       ov_q;
  logic [4:0] oe_q;
  logic       oh_q;
  logic       od_q;
  status_e    os_q;

  logic [EW-1:0] ci;
  logic [EW-1:0] ei;
  logic [EW-1:0] ii;
  logic [BW-1:0] no;
  logic [LW-1:0] pl;
  logic [LW-1:0] nl;
  logic [LW-1:0] fl;
  logic          idx_ok;
  logic          out_load;

  assign ci     = cur_q[EW-1:0];
  assign ei     = ent_q[EW-1:0];
  assign ii     = EW'(item_q.idx);
  assign no     = item_q.bkt[BW-1:0];
  assign pl     = prev_q[ei];
  assign nl     = next_q[ei];
  assign fl     = first_q[no];
  assign idx_ok = (32'(item_q.idx) < NUM_BUFFERS);
  assign out_load = (state_q == S_OUT) && (!ov_q || out_ready_i);

  assign pop_ready_o       = (state_q == S_IDLE);
  assign out_valid_o       = ov_q;
  assign entry_index_o     = oe_q;
  assign hit_o             = oh_q;
  assign needs_disk_read_o = od_q;
  assign status_o          = os_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
      cur_q   <= NIL;
      ent_q   <= NIL;
      bk_q    <= '0;
      tries_q <= '0;
      for (int b = 0; b < NUM_BUCKETS; b++) begin
        first_q[b] <= (bend(b) >= bstart(b)) ? LW'(bend(b)) : NIL;
        last_q[b]  <= (bend(b) >= bstart(b)) ? LW'(bstart(b)) : NIL;
        for (int e = 0; e < NUM_BUFFERS; e++) begin
          if (e >= bstart(b) && e <= bend(b)) begin
            blk_q[e]  <= 32'(b);
            next_q[e] <= (e > bstart(b)) ? LW'(e - 1) : NIL;
            prev_q[e] <= (e < bend(b)) ? LW'(e + 1) : NIL;
          end
        end
      end
      for (int e = 0; e < NUM_BUFFERS; e++) begin
        dev_q[e]  <= '0;
        val_q[e]  <= 1'b0;
        refs_q[e] <= '0;
      end
    end else begin
      if (out_load) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (pop_valid_i) begin
            item_q <= pop_item_i;
            hit_q  <= 1'b0;
            disk_q <= 1'b0;
            st_q   <= ST_OK;
            ent_q  <= LW'(pop_item_i.idx);
            cur_q  <= first_q[pop_item_i.bkt[BW-1:0]];
            state_q <= (pop_item_i.op == OP_READ) ? S_HSCAN : S_RETAG;
          end
        end
        S_HSCAN: begin
          if (cur_q == NIL) begin
            bk_q    <= no;
            tries_q <= '0;
            state_q <= S_FHEAD;
          end else if (dev_q[ci] == item_q.dev && blk_q[ci] == item_q.blk) begin
            ent_q <= cur_q;
            hit_q <= 1'b1;
            if (refs_q[ci] == REFS_MAX) begin
              st_q <= ST_OVERFLOW;
            end else begin
              refs_q[ci] <= refs_q[ci] + 8'd1;
              disk_q     <= ~val_q[ci];
              val_q[ci]  <= 1'b1;
            end
            state_q <= S_OUT;
          end else begin
            cur_q <= next_q[ci];
          end
        end
        S_FHEAD: begin
          cur_q   <= first_q[bk_q];
          state_q <= S_FSCAN;
        end
        S_FSCAN: begin
          if (cur_q == NIL) begin
            if (tries_q == LAST_BKT) begin
              st_q    <= ST_NO_FREE;
              ent_q   <= '0;
              state_q <= S_OUT;
            end else begin
              tries_q <= tries_q + 1'b1;
              bk_q    <= (bk_q == LAST_BKT) ? '0 : bk_q + 1'b1;
              state_q <= S_FHEAD;
            end
          end else if (refs_q[ci] == 8'd0) begin
            ent_q   <= cur_q;
            state_q <= (bk_q != no) ? S_UNLINK : S_RETAG;
          end else begin
            cur_q <= next_q[ci];
          end
        end
        S_UNLINK: begin
          if (pl == NIL) begin
            first_q[bk_q] <= nl;
          end else begin
            next_q[pl[EW-1:0]] <= nl;
          end
          if (nl == NIL) begin
            last_q[bk_q] <= pl;
          end else begin
            prev_q[nl[EW-1:0]] <= pl;
          end
          state_q <= S_PUSH;
        end
        S_PUSH: begin
          next_q[ei] <= fl;
          prev_q[ei] <= NIL;
          if (fl == NIL) begin
            last_q[no] <= ent_q;
          end else begin
            prev_q[fl[EW-1:0]] <= ent_q;
          end
          first_q[no] <= ent_q;
          state_q     <= S_RETAG;
        end
        S_RETAG: begin
          if (item_q.op == OP_READ) begin
            dev_q[ei]  <= item_q.dev;
            blk_q[ei]  <= item_q.blk;
            refs_q[ei] <= 8'd1;
            val_q[ei]  <= 1'b1;
            disk_q     <= 1'b1;
          end else if (idx_ok) begin
            if (item_q.op == OP_PIN) begin
              if (refs_q[ii] == REFS_MAX) begin
                st_q <= ST_OVERFLOW;
              end else begin
                refs_q[ii] <= refs_q[ii] + 8'd1;
              end
            end else begin
              if (refs_q[ii] == 8'd0) begin
                st_q <= ST_UNDERFLOW;
              end else begin
                refs_q[ii] <= refs_q[ii] - 8'd1;
              end
            end
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            oe_q    <= 5'(ent_q);
            oh_q    <= hit_q;
            od_q    <= disk_q;
            os_q    <= st_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
